// ===== rtl/core/srdlr_pkg.sv =====
// Shared types and constants of the stereo downmix linear resampler.
package srdlr_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned PhaseW  = 21;
  localparam int unsigned StepW   = 20;
  localparam int unsigned FracW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned TdataInW = 2 * SampleW;

  localparam logic [PhaseW-1:0] PhaseOne   = PhaseW'(32'h1_0000);
  localparam logic [StepW-1:0]  StepReset  = StepW'(32'h1_0000);
  localparam logic              StereoReset = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PHASE_STEP  = 2'd0,
    REG_STEREO_MODE = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_WAIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // latch downmixed sample
    logic mul;     // register (cur - prev) * frac
    logic load;    // form result, advance phase
    logic finish;  // close item: rebase phase, keep sample
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic phase_ge_one;
    logic out_last;
  } dp_stat_t;

endpackage

// ===== rtl/core/stereo_downmix_linear_resampler_core.sv =====
// Top level of the stereo downmix linear-interpolation resampler.
// Input stream: one PCM pair per transfer, tdata = {right, left}, each
//   16-bit two's complement. The pair is averaged (floor) in stereo mode,
//   or the left sample is taken alone in mono mode.
// Output stream: interpolated mono samples at the output rate; tlast marks
//   the final result caused by one input transfer. An input can cause zero
//   results (phase already past one) or up to MAX_RUN results.
// Config channel: cfg_index_i 0 = phase_step (Q16, input per output step),
//   1 = stereo_mode. Writes are taken only while the block is idle and no
//   input is offered, so an item never sees half of a config change.
// Timing: one input transfer, then per result the steps multiply, add into
//   the output register and present. An item with no result goes from the
//   multiply step straight back to idle.
//   Items are processed one at a time: the single shared multiplier and the
//   phase accumulator are the limiting path.
// Stall: while m_axis_tready_i is low the result stays in the output
//   register and no new input is taken.
// Reset: phase and previous sample clear to zero, phase_step to 1.0,
//   stereo_mode to 1; the block is ready for input right after reset.
module stereo_downmix_linear_resampler_core
  import srdlr_pkg::*;
#(
  parameter int unsigned MAX_RUN = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [TdataInW-1:0]  s_axis_tdata_i,   // [15:0] left_sample, [31:16] right_sample
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [SampleW-1:0]   m_axis_tdata_o,   // [15:0] out_sample
  output logic                 m_axis_tlast_o,   // last_of_run
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [StepW-1:0]     cfg_data_i
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     idle;
  logic signed [SampleW-1:0] out_sample;

  srdlr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .idle_o      (idle),
    .cmd_o       (cmd)
  );

  srdlr_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .left_i       (s_axis_tdata_i[SampleW-1:0]),
    .right_i      (s_axis_tdata_i[TdataInW-1:SampleW]),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .stat_o       (stat),
    .out_sample_o (out_sample)
  );

  // an offered input transfer wins over a config write in the same cycle
  assign cfg_ready_o    = idle && !s_axis_tvalid_i;
  assign m_axis_tdata_o = out_sample;
  assign m_axis_tlast_o = stat.out_last;

endmodule

// ===== rtl/core/srdlr_ctrl.sv =====
// Sequencing state machine of the resampler.
module srdlr_ctrl
  import srdlr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  output logic     idle_o,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = stat_i.phase_ge_one ? ST_IDLE : ST_LOAD;
      end
      ST_LOAD: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_ready_i) state_d = stat_i.out_last ? ST_IDLE : ST_MUL;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    idle_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        idle_o      = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_MUL: begin
        cmd_o.finish = stat_i.phase_ge_one;
        cmd_o.mul    = !stat_i.phase_ge_one;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
      end
      ST_WAIT: begin
        out_valid_o  = 1'b1;
        cmd_o.finish = out_ready_i && stat_i.out_last;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/core/srdlr_datapath.sv =====
// Downmix, phase accumulator, interpolation multiplier and output register.
module srdlr_datapath
  import srdlr_pkg::*;
#(
  parameter int unsigned MAX_RUN = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dp_cmd_t                    cmd_i,
  input  logic signed [SampleW-1:0]  left_i,
  input  logic signed [SampleW-1:0]  right_i,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [StepW-1:0]           cfg_data_i,
  output dp_stat_t                   stat_o,
  output logic signed [SampleW-1:0]  out_sample_o
);

  localparam int unsigned CntW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(MAX_RUN - 1);

  logic [StepW-1:0]          step_q;
  logic                      stereo_q;
  logic [PhaseW-1:0]         phase_q;
  logic signed [SampleW-1:0] prev_q;
  logic signed [SampleW-1:0] cur_q;
  logic signed [SampleW-1:0] prod_q;
  logic [CntW-1:0]           cnt_q;
  logic signed [SampleW-1:0] out_sample_q;
  logic                      out_last_q;

  logic signed [SampleW:0]   sum;
  logic signed [SampleW-1:0] mono;
  logic signed [SampleW:0]   diff;
  logic signed [FracW:0]     frac;
  logic signed [2*SampleW+1:0] prod_d;
  logic [PhaseW-1:0]         phase_next;
  logic                      phase_ge_one;
  logic                      last_d;

  // floor((l + r) / 2) is the upper bits of the 17-bit sum
  assign sum  = {left_i[SampleW-1], left_i} + {right_i[SampleW-1], right_i};
  assign mono = stereo_q ? sum[SampleW:1] : left_i;

  assign diff   = {cur_q[SampleW-1], cur_q} - {prev_q[SampleW-1], prev_q};
  assign frac   = {1'b0, phase_q[FracW-1:0]};
  assign prod_d = diff * frac;

  assign phase_next   = phase_q + {1'b0, step_q};
  assign phase_ge_one = phase_q >= PhaseOne;
  assign last_d       = (phase_next >= PhaseOne) || (cnt_q == CntLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= StepReset;
      stereo_q   <= StereoReset;
      phase_q    <= '0;
      prev_q     <= '0;
      cnt_q      <= '0;
      out_last_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_PHASE_STEP:  step_q   <= cfg_data_i;
          REG_STEREO_MODE: stereo_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        phase_q    <= phase_next;
        out_last_q <= last_d;
        if (!last_d) cnt_q <= cnt_q + CntW'(1);
      end else if (cmd_i.finish) begin
        // run cap with phase still below one rebases to zero
        phase_q <= phase_ge_one ? (phase_q - PhaseOne) : '0;
        prev_q  <= cur_q;
        cnt_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) cur_q <= mono;
    if (cmd_i.mul) prod_q <= prod_d[FracW+SampleW-1:FracW];
    if (cmd_i.load) out_sample_q <= prev_q + prod_q;
  end

  assign stat_o.phase_ge_one = phase_ge_one;
  assign stat_o.out_last     = out_last_q;
  assign out_sample_o        = out_sample_q;

endmodule

// ===== rtl/core/srdlr_checker.sv =====
// Port-level checker for the resampler core, bound to the top level.
module srdlr_checker
  import srdlr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [SampleW-1:0]  m_axis_tdata_o,
  input logic                m_axis_tlast_o,
  input logic                cfg_ready_o
);

  // one item at a time: never ready for input while a result is shown
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while result pending");

  // a result needs the multiply and add cycles after an input transfer
  a_in_to_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !m_axis_tvalid_o)
    else $error("result too early after input transfer");

  // more results of the same run follow a non-last output transfer
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> !s_axis_tready_o)
    else $error("input taken before run ended");

  // config is only open while idle
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> (s_axis_tready_o && !m_axis_tvalid_o))
    else $error("config open while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled result changed");

endmodule

bind stereo_downmix_linear_resampler_core srdlr_checker u_srdlr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .cfg_ready_o     (cfg_ready_o)
);
